### design/huffman_build_encode_decode_core_macros.svh
// Assertion macros shared by the Huffman core checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef HUFFMAN_BUILD_ENCODE_DECODE_CORE_MACROS_SVH
`define HUFFMAN_BUILD_ENCODE_DECODE_CORE_MACROS_SVH

// Check a property while reset is released
`define HBED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included
`define HBED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/hbed_pkg.sv
// Package for the Huffman build/encode/decode core: transfer structs, codes, helpers.
// No dependencies.
`timescale 1ns / 1ps

package hbed_pkg;

    // Input item kinds
    localparam logic [2:0] K_COUNT  = 3'd0;
    localparam logic [2:0] K_BUILD  = 3'd1;
    localparam logic [2:0] K_ENCODE = 3'd2;
    localparam logic [2:0] K_DECODE = 3'd3;
    localparam logic [2:0] K_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SINGLE  = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_NO_TREE = 3'd3;
    localparam logic [2:0] ST_NO_SYM  = 3'd4;

    localparam logic [7:0] NO_SYMBOL = 8'hFF;
    localparam int         WL_BITS   = 28;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] symbol_char;
        logic       code_bit_in;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic               code_bit;
        logic [7:0]         decoded_char;
        logic               last;
        logic [5:0]         leaf_total;
        logic [WL_BITS-1:0] weighted_length;
    } t_out;

    // Map a character to its alphabet index, NO_SYMBOL when outside
    function automatic logic [7:0] char_to_index(input logic [7:0] c);
        logic [7:0] idx;
        idx = NO_SYMBOL;
        if (c == 8'h20) begin
            idx = 8'd0;
        end else if (c == 8'h2E) begin
            idx = 8'd1;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            idx = c - 8'h41 + 8'd2;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            idx = c - 8'h61 + 8'd28;
        end
        return idx;
    endfunction

    // Map an alphabet index back to its character, zero past the alphabet
    function automatic logic [7:0] index_to_char(input logic [7:0] idx);
        logic [7:0] c;
        if (idx == 8'd0) begin
            c = 8'h20;
        end else if (idx == 8'd1) begin
            c = 8'h2E;
        end else if (idx < 8'd28) begin
            c = 8'h41 + idx - 8'd2;
        end else if (idx < 8'd54) begin
            c = 8'h61 + idx - 8'd28;
        end else begin
            c = 8'h00;
        end
        return c;
    endfunction

endpackage

### design/hbed_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hbed_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write and register the read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/huffman_build_encode_decode_core.sv
// Huffman core, one item in flight; busy stays high until the item is done. Count does a saturating
// increment; encode climbs from the leaf to the root, then emits its code bits; decode steps one
// tree level per item. Build gathers nonzero counts as leaves in alphabet order, runs two weight
// scans over the node weight RAM (one read port) per merge, then sums count times depth per leaf.
// Synchronous active-low reset clears counters' valid bits and the tree-ready flag.
// Depends on hbed_pkg and hbed_ram.
`timescale 1ns / 1ps

module huffman_build_encode_decode_core #(
    parameter int ALPHABET_SIZE = 54,
    parameter int COUNT_BITS    = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  hbed_pkg::t_in  i_in,
    output logic           busy,
    output logic           o_valid,
    output hbed_pkg::t_out o_result
);

    import hbed_pkg::*;

    localparam int A  = ALPHABET_SIZE;
    localparam int NT = 2 * A - 1;
    localparam int NB = $clog2(NT);
    localparam int AW = $clog2(A);
    localparam int LW = $clog2(A + 1);
    localparam int WW = COUNT_BITS + AW;
    localparam int DW = A - 1;
    localparam int PW = AW + WW;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_CNT_UPD = 5'd2;
    localparam logic [4:0] S_G_RD    = 5'd3;
    localparam logic [4:0] S_G_WR    = 5'd4;
    localparam logic [4:0] S_G_END   = 5'd5;
    localparam logic [4:0] S_SCAN    = 5'd6;
    localparam logic [4:0] S_MRG1    = 5'd7;
    localparam logic [4:0] S_MRG2    = 5'd8;
    localparam logic [4:0] S_WL_RD   = 5'd9;
    localparam logic [4:0] S_WL_DAT  = 5'd10;
    localparam logic [4:0] S_E_LOOK  = 5'd11;
    localparam logic [4:0] S_E_UP_RD = 5'd12;
    localparam logic [4:0] S_E_UP_Q  = 5'd13;
    localparam logic [4:0] S_E_UP_L  = 5'd14;
    localparam logic [4:0] S_E_EMIT  = 5'd15;
    localparam logic [4:0] S_D_CH    = 5'd16;
    localparam logic [4:0] S_D_SYM   = 5'd17;

    // Control registers
    logic [4:0]         r_state, n_state;
    logic [A-1:0]       r_cnt_v, n_cnt_v;
    logic [A-1:0]       r_in_tree, n_in_tree;
    logic [NT-1:0]      r_used, n_used;
    logic               r_ready, n_ready;
    logic [LW-1:0]      r_n, n_n;
    logic [NB-1:0]      r_dec, n_dec;
    logic               r_valid, n_valid;

    // Working registers
    t_in                r_in, n_in;
    t_out               r_res, n_res;
    logic [LW-1:0]      r_i, n_i;
    logic [NB-1:0]      r_k, n_k;
    logic [NB-1:0]      r_j, n_j;
    logic               r_dv, n_dv;
    logic [NB-1:0]      r_di, n_di;
    logic               r_pass, n_pass;
    logic               r_have, n_have;
    logic [NB-1:0]      r_best, n_best;
    logic [WW-1:0]      r_bw, n_bw;
    logic [NB-1:0]      r_s1, n_s1;
    logic [WW-1:0]      r_w1, n_w1;
    logic [NB-1:0]      r_p, n_p;
    logic [NB-1:0]      r_q, n_q;
    logic [AW-1:0]      r_depth, n_depth;
    logic [WW-1:0]      r_lw, n_lw;
    logic [WL_BITS-1:0] r_acc, n_acc;
    logic [DW-1:0]      r_bits, n_bits;
    logic [AW-1:0]      r_len, n_len;
    logic               r_single, n_single;

    // RAM ports
    logic          cnt_we, wt_we, par_we, lft_we, rgt_we, lsym_we, s2l_we;
    logic [AW-1:0] cnt_waddr, cnt_raddr, lsym_waddr, lsym_raddr, s2l_waddr, s2l_raddr;
    logic [NB-1:0] wt_waddr, wt_raddr, par_waddr, par_raddr;
    logic [NB-1:0] lft_waddr, lft_raddr, rgt_waddr, rgt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
    logic [WW-1:0] wt_wdata, wt_rd;
    logic [NB-1:0] par_wdata, par_rd, lft_wdata, lft_rd, rgt_wdata, rgt_rd;
    logic [AW-1:0] lsym_wdata, lsym_rd, s2l_wdata, s2l_rd;

    // Derived values
    logic [7:0]            sym_idx;
    logic                  sym_ok;
    logic [AW-1:0]         sym_a;
    logic [NB-1:0]         w_root;
    logic [NB-1:0]         dec_p;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [WW-1:0]         lw_eff;
    logic [AW-1:0]         depth_new;
    logic [PW-1:0]         prod;
    logic [NB-1:0]         child;

    assign sym_idx   = char_to_index(r_in.symbol_char);
    assign sym_ok    = (sym_idx < 8'(A));
    assign sym_a     = sym_idx[AW-1:0];
    assign w_root    = NB'({r_n, 1'b0}) - NB'(2);
    assign dec_p     = (r_dec < NB'(r_n) || r_dec > w_root) ? w_root : r_dec;
    assign cur_cnt   = r_cnt_v[sym_a] ? cnt_rd : '0;
    assign lw_eff    = (r_depth == '0) ? wt_rd : r_lw;
    assign depth_new = r_depth + AW'(1);
    assign prod      = PW'(depth_new) * PW'(lw_eff);
    assign child     = r_in.code_bit_in ? rgt_rd : lft_rd;

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt_v   = r_cnt_v;
        n_in_tree = r_in_tree;
        n_used    = r_used;
        n_ready   = r_ready;
        n_n       = r_n;
        n_dec     = r_dec;
        n_valid   = 1'b0;
        n_in      = r_in;
        n_res     = '0;
        n_i       = r_i;
        n_k       = r_k;
        n_j       = r_j;
        n_dv      = r_dv;
        n_di      = r_di;
        n_pass    = r_pass;
        n_have    = r_have;
        n_best    = r_best;
        n_bw      = r_bw;
        n_s1      = r_s1;
        n_w1      = r_w1;
        n_p       = r_p;
        n_q       = r_q;
        n_depth   = r_depth;
        n_lw      = r_lw;
        n_acc     = r_acc;
        n_bits    = r_bits;
        n_len     = r_len;
        n_single  = r_single;

        cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
        wt_we = 1'b0; wt_waddr = '0; wt_wdata = '0; wt_raddr = '0;
        par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_raddr = '0;
        lft_we = 1'b0; lft_waddr = '0; lft_wdata = '0; lft_raddr = '0;
        rgt_we = 1'b0; rgt_waddr = '0; rgt_wdata = '0; rgt_raddr = '0;
        lsym_we = 1'b0; lsym_waddr = '0; lsym_wdata = '0; lsym_raddr = '0;
        s2l_we = 1'b0; s2l_waddr = '0; s2l_wdata = '0; s2l_raddr = '0;

        case (r_state)
            S_IDLE: begin
                // Take a new transfer
                if (start) begin
                    n_in    = i_in;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                case (r_in.kind)
                    K_COUNT: begin
                        if (sym_ok) begin
                            cnt_raddr = sym_a;
                            n_state   = S_CNT_UPD;
                        end
                    end
                    K_BUILD: begin
                        n_in_tree = '0;
                        n_used    = '0;
                        n_n       = '0;
                        n_i       = '0;
                        n_state   = S_G_RD;
                    end
                    K_ENCODE: begin
                        if (!r_ready) begin
                            n_valid      = 1'b1;
                            n_res.status = ST_NO_TREE;
                            n_res.last   = 1'b1;
                        end else if (!sym_ok || !r_in_tree[sym_a]) begin
                            n_valid      = 1'b1;
                            n_res.status = ST_ABSENT;
                            n_res.last   = 1'b1;
                        end else if (r_n == LW'(1)) begin
                            n_valid      = 1'b1;
                            n_res.status = ST_SINGLE;
                            n_res.last   = 1'b1;
                        end else begin
                            s2l_raddr = sym_a;
                            n_state   = S_E_LOOK;
                        end
                    end
                    K_DECODE: begin
                        if (!r_ready) begin
                            n_valid      = 1'b1;
                            n_res.status = ST_NO_TREE;
                            n_res.last   = 1'b1;
                        end else if (r_n == LW'(1)) begin
                            lsym_raddr = '0;
                            n_single   = 1'b1;
                            n_state    = S_D_SYM;
                        end else begin
                            lft_raddr = dec_p;
                            rgt_raddr = dec_p;
                            n_single  = 1'b0;
                            n_state   = S_D_CH;
                        end
                    end
                    K_CLEAR: begin
                        n_cnt_v = '0;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CNT_UPD: begin
                // Saturating increment
                if (cur_cnt != '1) begin
                    cnt_we         = 1'b1;
                    cnt_waddr      = sym_a;
                    cnt_wdata      = cur_cnt + COUNT_BITS'(1);
                    n_cnt_v[sym_a] = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_G_RD: begin
                cnt_raddr = r_i[AW-1:0];
                n_state   = S_G_WR;
            end
            S_G_WR: begin
                // Gather nonzero counts as leaves in alphabet order
                if (r_cnt_v[r_i[AW-1:0]] && cnt_rd != '0) begin
                    wt_we      = 1'b1;
                    wt_waddr   = NB'(r_n);
                    wt_wdata   = WW'(cnt_rd);
                    lsym_we    = 1'b1;
                    lsym_waddr = r_n[AW-1:0];
                    lsym_wdata = r_i[AW-1:0];
                    s2l_we     = 1'b1;
                    s2l_waddr  = r_i[AW-1:0];
                    s2l_wdata  = r_n[AW-1:0];
                    n_in_tree[r_i[AW-1:0]] = 1'b1;
                    n_n        = r_n + LW'(1);
                end
                if (r_i == LW'(A - 1)) begin
                    n_state = S_G_END;
                end else begin
                    n_i     = r_i + LW'(1);
                    n_state = S_G_RD;
                end
            end
            S_G_END: begin
                if (r_n == '0) begin
                    n_valid      = 1'b1;
                    n_res.status = ST_NO_SYM;
                    n_res.last   = 1'b1;
                    n_ready      = 1'b0;
                    n_dec        = '0;
                    n_state      = S_IDLE;
                end else if (r_n == LW'(1)) begin
                    n_valid          = 1'b1;
                    n_res.status     = ST_SINGLE;
                    n_res.last       = 1'b1;
                    n_res.leaf_total = 6'd1;
                    n_ready          = 1'b1;
                    n_dec            = '0;
                    n_state          = S_IDLE;
                end else begin
                    n_j     = NB'(r_n);
                    n_k     = '0;
                    n_dv    = 1'b0;
                    n_pass  = 1'b0;
                    n_have  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Stream weights and keep the smallest free node
                wt_raddr = r_k;
                if (r_dv && !r_used[r_di] && !(r_pass && r_di == r_s1) &&
                    (!r_have || wt_rd < r_bw)) begin
                    n_best = r_di;
                    n_bw   = wt_rd;
                    n_have = 1'b1;
                end
                if (r_k < r_j) begin
                    n_dv = 1'b1;
                    n_di = r_k;
                    n_k  = r_k + NB'(1);
                end else begin
                    n_dv = 1'b0;
                    n_k  = '0;
                    if (!r_pass) begin
                        n_s1   = n_best;
                        n_w1   = n_bw;
                        n_pass = 1'b1;
                        n_have = 1'b0;
                    end else begin
                        n_state = S_MRG1;
                    end
                end
            end
            S_MRG1: begin
                wt_we     = 1'b1;
                wt_waddr  = r_j;
                wt_wdata  = r_w1 + r_bw;
                lft_we    = 1'b1;
                lft_waddr = r_j;
                lft_wdata = r_s1;
                rgt_we    = 1'b1;
                rgt_waddr = r_j;
                rgt_wdata = r_best;
                par_we    = 1'b1;
                par_waddr = r_s1;
                par_wdata = r_j;
                n_used[r_s1]   = 1'b1;
                n_used[r_best] = 1'b1;
                n_state   = S_MRG2;
            end
            S_MRG2: begin
                par_we    = 1'b1;
                par_waddr = r_best;
                par_wdata = r_j;
                if (r_j == w_root) begin
                    n_i     = '0;
                    n_p     = '0;
                    n_depth = '0;
                    n_acc   = '0;
                    n_state = S_WL_RD;
                end else begin
                    n_j     = r_j + NB'(1);
                    n_k     = '0;
                    n_dv    = 1'b0;
                    n_pass  = 1'b0;
                    n_have  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_WL_RD: begin
                par_raddr = r_p;
                wt_raddr  = NB'(r_i);
                n_state   = S_WL_DAT;
            end
            S_WL_DAT: begin
                // Climb toward the root, then add count times depth
                n_lw = lw_eff;
                if (par_rd == w_root) begin
                    n_acc = r_acc + WL_BITS'(prod);
                    if (r_i + LW'(1) == r_n) begin
                        n_valid               = 1'b1;
                        n_res.status          = ST_OK;
                        n_res.last            = 1'b1;
                        n_res.leaf_total      = 6'(r_n);
                        n_res.weighted_length = n_acc;
                        n_ready               = 1'b1;
                        n_dec                 = w_root;
                        n_state               = S_IDLE;
                    end else begin
                        n_i     = r_i + LW'(1);
                        n_p     = NB'(r_i + LW'(1));
                        n_depth = '0;
                        n_state = S_WL_RD;
                    end
                end else begin
                    n_p     = par_rd;
                    n_depth = depth_new;
                    n_state = S_WL_RD;
                end
            end
            S_E_LOOK: begin
                n_p     = NB'(s2l_rd);
                n_len   = '0;
                n_bits  = '0;
                n_state = S_E_UP_RD;
            end
            S_E_UP_RD: begin
                par_raddr = r_p;
                n_state   = S_E_UP_Q;
            end
            S_E_UP_Q: begin
                n_q       = par_rd;
                lft_raddr = par_rd;
                n_state   = S_E_UP_L;
            end
            S_E_UP_L: begin
                // Push one bit; the root-side bit ends up at the bottom
                n_bits = (r_bits << 1) | DW'(r_p != lft_rd);
                n_len  = r_len + AW'(1);
                n_p    = r_q;
                n_state = (r_q == w_root) ? S_E_EMIT : S_E_UP_RD;
            end
            S_E_EMIT: begin
                n_valid        = 1'b1;
                n_res.status   = ST_OK;
                n_res.code_bit = r_bits[0];
                n_res.last     = (r_len == AW'(1));
                n_bits         = r_bits >> 1;
                n_len          = r_len - AW'(1);
                if (r_len == AW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_D_CH: begin
                if (child < NB'(r_n)) begin
                    lsym_raddr = child[AW-1:0];
                    n_dec      = w_root;
                    n_state    = S_D_SYM;
                end else begin
                    n_dec   = (child <= w_root) ? child : w_root;
                    n_state = S_IDLE;
                end
            end
            S_D_SYM: begin
                n_valid            = 1'b1;
                n_res.status       = r_single ? ST_SINGLE : ST_OK;
                n_res.decoded_char = index_to_char(8'(lsym_rd));
                n_res.last         = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_v   <= '0;
            r_in_tree <= '0;
            r_used    <= '0;
            r_ready   <= 1'b0;
            r_n       <= '0;
            r_dec     <= '0;
            r_valid   <= 1'b0;
            r_single  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt_v   <= n_cnt_v;
            r_in_tree <= n_in_tree;
            r_used    <= n_used;
            r_ready   <= n_ready;
            r_n       <= n_n;
            r_dec     <= n_dec;
            r_valid   <= n_valid;
            r_single  <= n_single;
        end
    end

    // Working registers, no reset
    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_res   <= n_res;
        r_i     <= n_i;
        r_k     <= n_k;
        r_j     <= n_j;
        r_dv    <= n_dv;
        r_di    <= n_di;
        r_pass  <= n_pass;
        r_have  <= n_have;
        r_best  <= n_best;
        r_bw    <= n_bw;
        r_s1    <= n_s1;
        r_w1    <= n_w1;
        r_p     <= n_p;
        r_q     <= n_q;
        r_depth <= n_depth;
        r_lw    <= n_lw;
        r_acc   <= n_acc;
        r_bits  <= n_bits;
        r_len   <= n_len;
    end

    // Storage
    hbed_ram #(.W(COUNT_BITS), .D(A)) u_cnt_ram (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr), .o_rdata(cnt_rd)
    );
    hbed_ram #(.W(WW), .D(NT)) u_wt_ram (
        .i_clk(i_clk), .i_we(wt_we), .i_waddr(wt_waddr), .i_wdata(wt_wdata),
        .i_raddr(wt_raddr), .o_rdata(wt_rd)
    );
    hbed_ram #(.W(NB), .D(NT)) u_par_ram (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_raddr(par_raddr), .o_rdata(par_rd)
    );
    hbed_ram #(.W(NB), .D(NT)) u_lft_ram (
        .i_clk(i_clk), .i_we(lft_we), .i_waddr(lft_waddr), .i_wdata(lft_wdata),
        .i_raddr(lft_raddr), .o_rdata(lft_rd)
    );
    hbed_ram #(.W(NB), .D(NT)) u_rgt_ram (
        .i_clk(i_clk), .i_we(rgt_we), .i_waddr(rgt_waddr), .i_wdata(rgt_wdata),
        .i_raddr(rgt_raddr), .o_rdata(rgt_rd)
    );
    hbed_ram #(.W(AW), .D(A)) u_lsym_ram (
        .i_clk(i_clk), .i_we(lsym_we), .i_waddr(lsym_waddr), .i_wdata(lsym_wdata),
        .i_raddr(lsym_raddr), .o_rdata(lsym_rd)
    );
    hbed_ram #(.W(AW), .D(A)) u_s2l_ram (
        .i_clk(i_clk), .i_we(s2l_we), .i_waddr(s2l_waddr), .i_wdata(s2l_wdata),
        .i_raddr(s2l_raddr), .o_rdata(s2l_rd)
    );

endmodule

### design/hbed_checker.sv
// Port-level checker for the Huffman core, bound to the top level.
// Depends on hbed_pkg and huffman_build_encode_decode_core_macros.svh.
`timescale 1ns / 1ps
`include "huffman_build_encode_decode_core_macros.svh"

module hbed_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input hbed_pkg::t_out o_result
);

    import hbed_pkg::*;

    // An accepted transfer always occupies the core
    `HBED_ASSERT(a_accept_busy, start && !busy |=> busy, "accept did not raise busy")
    // Code bits come out back to back until the last one
    `HBED_ASSERT(a_burst, o_valid && !o_result.last |=> o_valid, "gap inside result burst")
    // A last result is never followed directly by another result
    `HBED_ASSERT(a_last_gap, o_valid && o_result.last |=> !o_valid, "result right after last")
    // Error and special statuses are single results
    `HBED_ASSERT(a_status_last, o_valid && o_result.status != ST_OK |-> o_result.last,
        "non-ok status without last")
    // Reset leaves the core idle with no strobe
    `HBED_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_valid && !busy, "reset not idle")

endmodule

bind huffman_build_encode_decode_core hbed_checker u_hbed_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_valid(o_valid),
    .o_result(o_result)
);
